[src/cau_pkg.sv]
`timescale 1ns / 1ps

package cau_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_TIMESI = 3'd3,
        OP_MUL   = 3'd4,
        OP_MAG   = 3'd5,
        OP_NONE  = 3'd6
    } op_t;

    function automatic op_t decode_op(input logic [2:0] code);
        op_t op;
        case (code)
            3'd0:    op = OP_ADD;
            3'd1:    op = OP_SUB;
            3'd2:    op = OP_SCALE;
            3'd3:    op = OP_TIMESI;
            3'd4:    op = OP_MUL;
            3'd5:    op = OP_MAG;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

[src/cau_front.sv]
`timescale 1ns / 1ps

module cau_front import cau_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [2:0]                   req_type,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    output logic                         q_valid,
    input  logic                         q_ready,
    output op_t                          q_op,
    output logic signed [DATA_WIDTH-1:0] q_a_re,
    output logic signed [DATA_WIDTH-1:0] q_a_im,
    output logic signed [DATA_WIDTH-1:0] q_b_re,
    output logic signed [DATA_WIDTH-1:0] q_b_im
);

    op_t                         op_reg   [QUEUE_DEPTH];
    logic signed [DATA_WIDTH-1:0] are_reg [QUEUE_DEPTH];
    logic signed [DATA_WIDTH-1:0] aim_reg [QUEUE_DEPTH];
    logic signed [DATA_WIDTH-1:0] bre_reg [QUEUE_DEPTH];
    logic signed [DATA_WIDTH-1:0] bim_reg [QUEUE_DEPTH];

    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                push, pop;

    assign req_stall = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_valid && q_ready;

    assign q_op   = op_reg[rd_ptr_reg];
    assign q_a_re = are_reg[rd_ptr_reg];
    assign q_a_im = aim_reg[rd_ptr_reg];
    assign q_b_re = bre_reg[rd_ptr_reg];
    assign q_b_im = bim_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // classify the opcode on entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wr_ptr_reg]  <= decode_op(req_type);
            are_reg[wr_ptr_reg] <= a_re;
            aim_reg[wr_ptr_reg] <= a_im;
            bre_reg[wr_ptr_reg] <= b_re;
            bim_reg[wr_ptr_reg] <= b_im;
        end
    end

endmodule

[src/cau_back.sv]
`timescale 1ns / 1ps

module cau_back import cau_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  op_t                          q_op,
    input  logic signed [DATA_WIDTH-1:0] q_a_re,
    input  logic signed [DATA_WIDTH-1:0] q_a_im,
    input  logic signed [DATA_WIDTH-1:0] q_b_re,
    input  logic signed [DATA_WIDTH-1:0] q_b_im,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output logic                         overflow
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW;
    localparam int WW = 2 * DW + 1;
    localparam logic signed [WW-1:0] MAXV = WW'((65'd1 << (DW - 1)) - 65'd1);
    localparam logic signed [WW-1:0] MINV = ~MAXV;

    logic en;

    // stage A: products and add/subtract
    logic                 va_reg;
    op_t                  opa_reg;
    logic signed [PW-1:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic signed [DW:0]   sre_reg, sim_reg;

    // stage B: combine, shift and saturate; square sum for the root
    logic                 vb_reg;
    logic signed [DW-1:0] reb_reg, imb_reg;
    logic                 ovfb_reg;
    logic                 magb_reg;
    logic [PW-1:0]        sqb_reg;

    logic signed [WW-1:0] wre, wim;
    logic signed [DW-1:0] re_sat, im_sat;
    logic                 ovf_re, ovf_im;

    // square-root stages, one result bit each
    logic                 vs_reg   [DW+1];
    logic                 mags_reg [DW+1];
    logic signed [DW-1:0] res_reg  [DW+1];
    logic signed [DW-1:0] ims_reg  [DW+1];
    logic                 ovfs_reg [DW+1];
    logic [PW-1:0]        rem_reg  [DW+1];
    logic [DW-1:0]        root_reg [DW+1];

    logic                 vo_reg;
    logic signed [DW-1:0] reo_reg, imo_reg;
    logic                 ovfo_reg;

    assign en      = !vo_reg || !res_stall;
    assign q_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= q_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            opa_reg <= q_op;
            m0_reg  <= q_a_re * ((q_op == OP_MAG) ? q_a_re : q_b_re);
            m1_reg  <= q_a_im * ((q_op == OP_MAG) ? q_a_im : q_b_im);
            m2_reg  <= q_a_re * q_b_im;
            m3_reg  <= q_a_im * q_b_re;
            if (q_op == OP_SUB)
            begin
                sre_reg <= (DW+1)'(q_a_re) - (DW+1)'(q_b_re);
                sim_reg <= (DW+1)'(q_a_im) - (DW+1)'(q_b_im);
            end
            else
            begin
                sre_reg <= (DW+1)'(q_a_re) + (DW+1)'(q_b_re);
                sim_reg <= (DW+1)'(q_a_im) + (DW+1)'(q_b_im);
            end
        end
    end

    always_comb
    begin
        case (opa_reg)
            OP_ADD, OP_SUB:
            begin
                wre = WW'(sre_reg);
                wim = WW'(sim_reg);
            end
            OP_SCALE:
            begin
                wre = WW'(m0_reg) >>> FRAC_BITS;
                wim = WW'(m3_reg) >>> FRAC_BITS;
            end
            OP_TIMESI:
            begin
                wre = (-WW'(m1_reg)) >>> FRAC_BITS;
                wim = WW'(m2_reg) >>> FRAC_BITS;
            end
            OP_MUL:
            begin
                wre = (WW'(m0_reg) - WW'(m1_reg)) >>> FRAC_BITS;
                wim = (WW'(m2_reg) + WW'(m3_reg)) >>> FRAC_BITS;
            end
            default:
            begin
                wre = '0;
                wim = '0;
            end
        endcase
        ovf_re = (wre > MAXV) || (wre < MINV);
        ovf_im = (wim > MAXV) || (wim < MINV);
        re_sat = (wre > MAXV) ? DW'(MAXV) : (wre < MINV) ? DW'(MINV) : DW'(wre);
        im_sat = (wim > MAXV) ? DW'(MAXV) : (wim < MINV) ? DW'(MINV) : DW'(wim);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            reb_reg  <= re_sat;
            imb_reg  <= im_sat;
            ovfb_reg <= ovf_re || ovf_im;
            magb_reg <= (opa_reg == OP_MAG);
            sqb_reg  <= PW'(m0_reg) + PW'(m1_reg);
        end
    end

    assign vs_reg[0]   = vb_reg;
    assign mags_reg[0] = magb_reg;
    assign res_reg[0]  = reb_reg;
    assign ims_reg[0]  = imb_reg;
    assign ovfs_reg[0] = ovfb_reg;
    assign rem_reg[0]  = sqb_reg;
    assign root_reg[0] = '0;

    for (genvar k = 0; k < DW; k++)
    begin : g_sqrt
        localparam int BIT = DW - 1 - k;
        logic [PW-1:0] trial;
        logic          take;

        assign trial = (PW'(root_reg[k]) << (BIT + 1)) | (PW'(1) << (2 * BIT));
        assign take  = (rem_reg[k] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vs_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vs_reg[k+1] <= vs_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mags_reg[k+1] <= mags_reg[k];
                res_reg[k+1]  <= res_reg[k];
                ims_reg[k+1]  <= ims_reg[k];
                ovfs_reg[k+1] <= ovfs_reg[k];
                rem_reg[k+1]  <= take ? rem_reg[k] - trial : rem_reg[k];
                root_reg[k+1] <= take ? (root_reg[k] | (DW'(1) << BIT)) : root_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= vs_reg[DW];
        end
    end

    // magnitude saturates when the top root bit is set
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (mags_reg[DW])
            begin
                reo_reg  <= root_reg[DW][DW-1] ? DW'(MAXV) : root_reg[DW];
                imo_reg  <= '0;
                ovfo_reg <= root_reg[DW][DW-1];
            end
            else
            begin
                reo_reg  <= res_reg[DW];
                imo_reg  <= ims_reg[DW];
                ovfo_reg <= ovfs_reg[DW];
            end
        end
    end

    assign res_valid = vo_reg;
    assign res_re    = reo_reg;
    assign res_im    = imo_reg;
    assign overflow  = ovfo_reg;

endmodule

[src/complex_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Channel  | handshake             | payload
// request  | req_valid, req_stall  | req_type, a_re, a_im, b_re, b_im
// result   | res_valid, res_stall  | res_re, res_im, overflow
//
// One request per cycle sustained while the result side does not stall; from
// leaving the input queue, every request passes through stage A, stage B, the
// one-bit-per-stage square-root pipeline and the output register, to keep order.
// Reset clears the queue and all stage valid bits.
// A result stall with a result waiting freezes the back pipeline; the four-entry
// queue keeps taking requests until full.

module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [2:0]                   req_type,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output logic                         overflow
);

    logic                         q_valid, q_ready;
    op_t                          q_op;
    logic signed [DATA_WIDTH-1:0] q_a_re, q_a_im, q_b_re, q_b_im;

    cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
        .q_a_re(q_a_re), .q_a_im(q_a_im), .q_b_re(q_b_re), .q_b_im(q_b_im)
    );

    cau_back #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
        .q_a_re(q_a_re), .q_a_im(q_a_im), .q_b_re(q_b_re), .q_b_im(q_b_im),
        .res_valid(res_valid), .res_stall(res_stall),
        .res_re(res_re), .res_im(res_im), .overflow(overflow)
    );

endmodule

[src/cau_checker.sv]
`timescale 1ns / 1ps

module cau_checker import cau_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_stall,
    input logic                         res_valid,
    input logic                         res_stall,
    input logic signed [DATA_WIDTH-1:0] res_re,
    input logic signed [DATA_WIDTH-1:0] res_im,
    input logic                         overflow
);

    localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_re) && $stable(res_im) && $stable(overflow))
        else $error("stalled result changed");

    // the queue fills only by taking a request
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(req_stall) |-> $past(req_valid))
        else $error("queue filled without a request");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && overflow |-> (res_re == SMAX || res_re == SMIN
                                   || res_im == SMAX || res_im == SMIN))
        else $error("overflow without a saturated part");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);

[verif/complex_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int DW        = DATA_WIDTH_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = DW + 3 + QUEUE_DEPTH + 4;
    localparam int N_RANDOM  = 1850;
    localparam int HOLD_LEN  = 300;
    localparam int STALL_MAX = HOLD_LEN + 50;

    localparam logic signed [DW-1:0] QMAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] QMIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] QONE  = 1 <<< FB;
    localparam logic signed [DW-1:0] QZERO = '0;

    typedef struct packed {
        logic [2:0]           kind;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
    } request_t;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 ovf;
    } answer_t;

    typedef struct packed {
        request_t req;
        logic     known;
        answer_t  ans;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    logic [2:0]           req_type;
    logic signed [DW-1:0] a_re, a_im, b_re, b_im;
    logic                 res_valid;
    logic                 res_stall;
    logic signed [DW-1:0] res_re, res_im;
    logic                 overflow;

    answer_t answers_due[$];
    int      mismatches;
    int      idle_cycles = 0;
    bit      quiet;
    bit      hold_req;

    complex_arithmetic_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_re    (res_re),
        .res_im    (res_im),
        .overflow  (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // saturate a wide signed value to the result width
    function automatic logic signed [DW-1:0] clamp(input logic signed [2*DW+3:0] v,
                                                   inout logic ovf);
        if (v > QMAX)
        begin
            ovf = 1'b1;
            return QMAX;
        end
        if (v < QMIN)
        begin
            ovf = 1'b1;
            return QMIN;
        end
        return v[DW-1:0];
    endfunction

    function automatic answer_t complex_result(input request_t r);
        answer_t                 a;
        logic signed [2*DW+3:0]  ar, ai, br, bi, x, y;
        logic [2*DW+3:0]         sq, root, cand;
        a = '0;
        ar = r.ar; ai = r.ai; br = r.br; bi = r.bi;
        case (r.kind)
            OP_ADD:
            begin
                a.re = clamp(ar + br, a.ovf);
                a.im = clamp(ai + bi, a.ovf);
            end
            OP_SUB:
            begin
                a.re = clamp(ar - br, a.ovf);
                a.im = clamp(ai - bi, a.ovf);
            end
            OP_SCALE:
            begin
                x = (ar * br) >>> FB;
                y = (ai * br) >>> FB;
                a.re = clamp(x, a.ovf);
                a.im = clamp(y, a.ovf);
            end
            OP_TIMESI:
            begin
                x = (-(bi * ai)) >>> FB;
                y = (bi * ar) >>> FB;
                a.re = clamp(x, a.ovf);
                a.im = clamp(y, a.ovf);
            end
            OP_MUL:
            begin
                x = (ar * br - ai * bi) >>> FB;
                y = (ar * bi + ai * br) >>> FB;
                a.re = clamp(x, a.ovf);
                a.im = clamp(y, a.ovf);
            end
            OP_MAG:
            begin
                sq = ar * ar + ai * ai;
                root = '0;
                for (int k = DW; k >= 0; k--)
                begin
                    cand = root | (1 << k);
                    if (cand * cand <= sq)
                        root = cand;
                end
                a.re = clamp(root, a.ovf);
            end
            default:
                a = '0;
        endcase
        return a;
    endfunction

    task automatic report(input string what, input answer_t got, input answer_t want);
        mismatches++;
        $display("mismatch %s: got %h %h %b, want %h %h %b at %0t", what,
                 got.re, got.im, got.ovf, want.re, want.im, want.ovf, $realtime);
    endtask

    // send one request; hold it until accepted
    task automatic send(input request_t r, input bit use_gaps);
        while (use_gaps && !quiet && $urandom_range(99) < 16)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= r.kind;
        a_re      <= r.ar;
        a_im      <= r.ai;
        b_re      <= r.br;
        b_im      <= r.bi;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        answers_due.push_back(complex_result(r));
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(7))
            0: return QMAX;
            1: return QMIN;
            2: return $signed($urandom_range(QONE * 4)) - QONE * 2;
            3: return $signed($urandom) >>> $urandom_range(24);
            4: return $urandom_range(1) ? QONE : -QONE;
            default: return $urandom;
        endcase
    endfunction

    row_t    plan[$];
    answer_t want_row[$];

    task automatic add_row(input logic [2:0] k, input logic signed [DW-1:0] ar, ai, br, bi,
                           input bit known, input answer_t ans);
        row_t row;
        row.req = '{k, ar, ai, br, bi};
        row.known = known;
        row.ans = ans;
        plan.push_back(row);
    endtask

    // result side: random stall plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= hold_req || (!quiet && $urandom_range(99) < 16);
    end

    always @(posedge clk)
    begin
        answer_t got, want;
        if (rst_n && res_valid && !res_stall)
        begin
            got = '{res_re, res_im, overflow};
            if (answers_due.size() == 0)
                report("unexpected result", got, '0);
            else
            begin
                want = answers_due.pop_front();
                if (got.re !== want.re)
                    report("res_re", got, want);
                if (got.im !== want.im)
                    report("res_im", got, want);
                if (got.ovf !== want.ovf)
                    report("overflow", got, want);
            end
        end
    end

    // drop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_MAX + 1000)
        begin
            $display("complex_arithmetic_unit test failed");
            $finish;
        end
    end

    initial
    begin
        request_t r;
        answer_t  none;
        mismatches  = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_type    = OP_ADD;
        a_re = '0; a_im = '0; b_re = '0; b_im = '0;
        none = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(OP_ADD, QZERO, QZERO, QZERO, QZERO, 1, '{QZERO, QZERO, 1'b0});
        add_row(OP_ADD, QMAX, QMIN, QONE, -QONE, 1, '{QMAX, QMIN, 1'b1});
        add_row(OP_ADD, QMAX, QMAX, QMIN, QMIN, 1, '{-1, -1, 1'b0});
        add_row(OP_SUB, QMIN, QMAX, QONE, -QONE, 1, '{QMIN, QMAX, 1'b1});
        add_row(OP_SUB, QONE, QONE, QONE, QZERO, 1, '{QZERO, QONE, 1'b0});
        add_row(OP_SCALE, QONE, -QONE, QONE, QZERO, 1, '{QONE, -QONE, 1'b0});
        add_row(OP_SCALE, QMAX, QMIN, QMAX, QZERO, 1, '{QMAX, QMIN, 1'b1});
        add_row(OP_SCALE, QMIN, QMIN, QMIN, QMAX, 0, none);
        add_row(OP_TIMESI, QONE, QONE, QZERO, QONE, 1, '{-QONE, QONE, 1'b0});
        add_row(OP_TIMESI, QMIN, QMIN, QZERO, QMIN, 0, none);
        add_row(OP_MUL, QONE, QONE, QONE, -QONE, 1, '{2 * QONE, QZERO, 1'b0});
        add_row(OP_MUL, QMAX, QMIN, QMAX, QMIN, 0, none);
        add_row(OP_MUL, QMIN, QMIN, QMIN, QMIN, 0, none);
        add_row(OP_MUL, -1, 1, 1, 1, 0, none);
        add_row(OP_MAG, 3 * QONE, 4 * QONE, QMAX, QMIN, 0, none);
        add_row(OP_MAG, QMIN, QMIN, QZERO, QZERO, 1, '{QMAX, QZERO, 1'b1});
        add_row(OP_MAG, QZERO, QZERO, QZERO, QZERO, 1, '{QZERO, QZERO, 1'b0});
        add_row(OP_MAG, 3, 4, 0, 0, 1, '{5, QZERO, 1'b0});
        add_row(OP_NONE, QMAX, QMIN, QMAX, QMIN, 1, '{QZERO, QZERO, 1'b0});
        add_row(3'd7, QMIN, QMAX, -1, -1, 1, '{QZERO, QZERO, 1'b0});

        foreach (plan[i])
        begin
            if (plan[i].known && complex_result(plan[i].req) !== plan[i].ans)
                report("table row", complex_result(plan[i].req), plan[i].ans);
            send(plan[i].req, 1);
        end

        // let everything drain before the random part
        req_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            quiet = (n >= 400 && n < 600);
            if (n == 800)
                fork
                    begin
                        hold_req = 1'b1;
                        repeat (HOLD_LEN) @(posedge clk);
                        hold_req = 1'b0;
                    end
                join_none
            if (n == 1200)
            begin
                req_valid <= 1'b0;
                while (answers_due.size() != 0)
                    @(posedge clk);
            end
            r.kind = $urandom_range(7);
            r.ar = pick_value();
            r.ai = pick_value();
            r.br = pick_value();
            r.bi = pick_value();
            send(r, 1);
        end
        req_valid <= 1'b0;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);

        if (mismatches == 0)
            $display("complex_arithmetic_unit test passed");
        else
            $display("complex_arithmetic_unit test failed");
        $finish;
    end

endmodule
